// ===== hw/rtl/kdc_pkg.sv =====
// Shared types and constants for the keyboard/display controller.
// No dependencies; every other file imports this package.
package kdc_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_STATUS = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_CMD    = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_PUSH   = 3'd4;

    // Command groups, taken from bits 7..5 of a command byte.
    localparam logic [2:0] CMD_KBD_MODE    = 3'd0;
    localparam logic [2:0] CMD_CLOCK_DIV   = 3'd1;
    localparam logic [2:0] CMD_SEL_FIFO    = 3'd2;
    localparam logic [2:0] CMD_READ_DISP   = 3'd3;
    localparam logic [2:0] CMD_WRITE_DISP  = 3'd4;
    localparam logic [2:0] CMD_DISP_MASK   = 3'd5;
    localparam logic [2:0] CMD_CLEAR_ALL   = 3'd6;
    localparam logic [2:0] CMD_CLEAR_FLAGS = 3'd7;

    // Data port selection.
    localparam logic [1:0] IO_FIFO     = 2'd0;
    localparam logic [1:0] IO_SENSOR   = 2'd1;
    localparam logic [1:0] IO_DISP_RD  = 2'd2;
    localparam logic [1:0] IO_DISP_WR  = 2'd3;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_BUSY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ROWS  = 1'b1;

    // Sensor matrix: eight rows of eight bits.
    localparam int SENSOR_AW = 3;
    // Fill count bits reported in the status byte.
    localparam int STAT_FILL_W = 3;
    // Returned on a read of an empty key FIFO.
    localparam logic [7:0] EMPTY_READ_VALUE = 8'hFF;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
    } kdc_req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       key_accepted;
        logic       irq_out;
    } kdc_result_t;

    // Key FIFO controls issued by the request decoder.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] push_data;
    } kdc_fifo_ctrl_t;

    // Display store controls issued by the request decoder.
    typedef struct packed {
        logic       wr_en;
        logic       clear;
        logic       inhibit_low;
        logic       inhibit_high;
        logic [7:0] wr_data;
    } kdc_disp_ctrl_t;

endpackage

// ===== hw/rtl/kdc_key_fifo.sv =====
// Eight-entry key FIFO with head pointer and fill count.
// Depends on kdc_pkg for the control struct.
module kdc_key_fifo
    import kdc_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  kdc_fifo_ctrl_t                 ctrl,
    output logic [$clog2(DEPTH+1)-1:0]     fill,
    output logic [7:0]                     head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [AW-1:0] tail;

    // The free slot sits fill entries past the head.
    assign tail = head_reg + fill_reg[AW-1:0];

    // Pointer and count update; push and pop never come together.
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (ctrl.pop)
        begin
            head_next = head_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Key storage holds no reset value.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= ctrl.push_data;
        end
    end

    assign fill      = fill_reg;
    assign head_data = mem[head_reg];

endmodule

// ===== hw/rtl/kdc_disp_store.sv =====
// Sixteen-byte display store with nibble write inhibits and a full clear.
// Depends on kdc_pkg for the control struct.
module kdc_disp_store
    import kdc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  kdc_disp_ctrl_t           ctrl,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [7:0]               rd_data
);

    logic [7:0] store_reg [DEPTH];
    logic [7:0] cell_next;

    // Inhibited nibbles keep their old contents.
    always_comb
    begin
        cell_next = store_reg[addr];
        if (!ctrl.inhibit_low)
        begin
            cell_next[3:0] = ctrl.wr_data[3:0];
        end
        if (!ctrl.inhibit_high)
        begin
            cell_next[7:4] = ctrl.wr_data[7:4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            store_reg[addr] <= cell_next;
        end
    end

    assign rd_data = store_reg[addr];

endmodule

// ===== hw/rtl/keyboard_display_controller.sv =====
// Keyboard/display controller top level: request register, decoder, mode registers and
// result register around kdc_key_fifo and kdc_disp_store; uses kdc_pkg.
// Each accepted request is captured in the request register, decoded, and its result and done
// are then held in the result register; the receiver cannot stall.
// Throughput: one request per cycle, busy never rises. Reset (rst_n, asynchronous, active
// low) clears flags, pointers, modes, the configuration registers and the display store.
module keyboard_display_controller
    import kdc_pkg::*;
#(
    parameter int FIFO_DEPTH    = 8,
    parameter int DISPLAY_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  kdc_req_t              req,
    output logic                  done,
    output kdc_result_t           result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W = $clog2(DISPLAY_DEPTH);

    // Configuration registers.
    logic                  display_busy_reg;
    logic [CFG_DATA_W-1:0] sensor_rows_reg;

    // Request register.
    logic     req_valid_reg;
    kdc_req_t req_reg;

    // Mode and flag registers.
    logic [ADDR_W-1:0] addr_reg,         addr_next;
    logic              auto_inc_reg,     auto_inc_next;
    logic [1:0]        io_sel_reg,       io_sel_next;
    logic [4:0]        kbd_mode_reg,     kbd_mode_next;
    logic [4:0]        clock_div_reg,    clock_div_next;
    logic              inhibit_low_reg,  inhibit_low_next;
    logic              inhibit_high_reg, inhibit_high_next;
    logic              blank_low_reg,    blank_low_next;
    logic              blank_high_reg,   blank_high_next;
    logic              underrun_reg,     underrun_next;
    logic              overrun_reg,      overrun_next;
    logic              irq_reg,          irq_next;

    // Result register.
    logic        done_reg;
    kdc_result_t result_reg, result_next;

    // Datapath links.
    kdc_fifo_ctrl_t    fifo_ctrl;
    kdc_disp_ctrl_t    disp_ctrl;
    logic [FILL_W-1:0] fifo_fill;
    logic [7:0]        key_head_byte;
    logic [7:0]        disp_rd;
    logic [7:0]        sensor_byte;
    logic [7:0]        status_byte;
    logic              fifo_full;
    logic [2:0]        cmd_group;
    logic [SENSOR_AW-1:0] sensor_addr_inc;

    // Every request is taken as it comes.
    assign busy = 1'b0;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_busy_reg <= 1'b0;
            sensor_rows_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISPLAY_BUSY: display_busy_reg <= cfg_data[0];
                CFG_SENSOR_ROWS:  sensor_rows_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    kdc_key_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .fill      (fifo_fill),
        .head_data (key_head_byte)
    );

    kdc_disp_store #(
        .DEPTH (DISPLAY_DEPTH)
    ) u_disp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (disp_ctrl),
        .addr    (addr_reg),
        .rd_data (disp_rd)
    );

    // Read sources.
    assign fifo_full       = (fifo_fill == FILL_W'(FIFO_DEPTH));
    assign sensor_byte     = sensor_rows_reg[addr_reg[SENSOR_AW-1:0]*8 +: 8];
    assign sensor_addr_inc = addr_reg[SENSOR_AW-1:0] + SENSOR_AW'(1);
    assign status_byte     = {display_busy_reg, 1'b0, overrun_reg, underrun_reg,
                              fifo_full, fifo_fill[STAT_FILL_W-1:0]};
    assign cmd_group       = req_reg.data_byte[7:5];

    // Request decoder and state update.
    always_comb
    begin
        addr_next         = addr_reg;
        auto_inc_next     = auto_inc_reg;
        io_sel_next       = io_sel_reg;
        kbd_mode_next     = kbd_mode_reg;
        clock_div_next    = clock_div_reg;
        inhibit_low_next  = inhibit_low_reg;
        inhibit_high_next = inhibit_high_reg;
        blank_low_next    = blank_low_reg;
        blank_high_next   = blank_high_reg;
        underrun_next     = underrun_reg;
        overrun_next      = overrun_reg;
        irq_next          = irq_reg;

        fifo_ctrl           = '0;
        fifo_ctrl.push_data = req_reg.data_byte;
        disp_ctrl              = '0;
        disp_ctrl.inhibit_low  = inhibit_low_reg;
        disp_ctrl.inhibit_high = inhibit_high_reg;
        disp_ctrl.wr_data      = req_reg.data_byte;

        result_next = '0;

        if (req_valid_reg)
        begin
            unique case (req_reg.req_type)
                REQ_STATUS:
                begin
                    result_next.read_value = status_byte;
                end
                REQ_READ:
                begin
                    if (io_sel_reg == IO_SENSOR)
                    begin
                        result_next.read_value = sensor_byte;
                        if (auto_inc_reg)
                        begin
                            addr_next = ADDR_W'(sensor_addr_inc);
                        end
                    end
                    else if (io_sel_reg == IO_DISP_RD)
                    begin
                        result_next.read_value = disp_rd;
                        if (auto_inc_reg)
                        begin
                            addr_next = addr_reg + ADDR_W'(1);
                        end
                    end
                    else if (fifo_fill == '0)
                    begin
                        // Read of an empty FIFO.
                        underrun_next          = 1'b1;
                        result_next.read_value = EMPTY_READ_VALUE;
                    end
                    else
                    begin
                        fifo_ctrl.pop          = 1'b1;
                        result_next.read_value = key_head_byte;
                        irq_next               = (fifo_fill != FILL_W'(1));
                    end
                end
                REQ_CMD:
                begin
                    unique case (cmd_group)
                        CMD_KBD_MODE:  kbd_mode_next  = req_reg.data_byte[4:0];
                        CMD_CLOCK_DIV: clock_div_next = req_reg.data_byte[4:0];
                        CMD_SEL_FIFO:
                        begin
                            io_sel_next   = req_reg.data_byte[4] ? IO_SENSOR : IO_FIFO;
                            auto_inc_next = req_reg.data_byte[4] & req_reg.data_byte[3];
                            addr_next     = ADDR_W'(req_reg.data_byte[2:0]);
                        end
                        CMD_READ_DISP:
                        begin
                            io_sel_next   = IO_DISP_RD;
                            auto_inc_next = req_reg.data_byte[4];
                            addr_next     = ADDR_W'(req_reg.data_byte[3:0]);
                        end
                        CMD_WRITE_DISP:
                        begin
                            io_sel_next   = IO_DISP_WR;
                            auto_inc_next = req_reg.data_byte[4];
                            addr_next     = ADDR_W'(req_reg.data_byte[3:0]);
                        end
                        CMD_DISP_MASK:
                        begin
                            inhibit_low_next  = req_reg.data_byte[3];
                            inhibit_high_next = req_reg.data_byte[2];
                            blank_low_next    = req_reg.data_byte[1];
                            blank_high_next   = req_reg.data_byte[0];
                        end
                        CMD_CLEAR_ALL:
                        begin
                            disp_ctrl.clear = 1'b1;
                            fifo_ctrl.clear = 1'b1;
                            irq_next        = 1'b0;
                            overrun_next    = 1'b0;
                            underrun_next   = 1'b0;
                        end
                        CMD_CLEAR_FLAGS:
                        begin
                            overrun_next  = 1'b0;
                            underrun_next = 1'b0;
                            irq_next      = (fifo_fill != '0);
                        end
                        default: ;
                    endcase
                end
                REQ_WRITE:
                begin
                    // Data writes only land in write-display selection.
                    if (io_sel_reg == IO_DISP_WR)
                    begin
                        disp_ctrl.wr_en = 1'b1;
                        if (auto_inc_reg)
                        begin
                            addr_next = addr_reg + ADDR_W'(1);
                        end
                    end
                end
                REQ_PUSH:
                begin
                    if (fifo_full)
                    begin
                        overrun_next = 1'b1;
                    end
                    else
                    begin
                        fifo_ctrl.push           = 1'b1;
                        result_next.key_accepted = 1'b1;
                        irq_next                 = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        result_next.irq_out = irq_next;
    end

    // Mode and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg         <= '0;
            auto_inc_reg     <= 1'b0;
            io_sel_reg       <= IO_FIFO;
            kbd_mode_reg     <= '0;
            clock_div_reg    <= '0;
            inhibit_low_reg  <= 1'b0;
            inhibit_high_reg <= 1'b0;
            blank_low_reg    <= 1'b0;
            blank_high_reg   <= 1'b0;
            underrun_reg     <= 1'b0;
            overrun_reg      <= 1'b0;
            irq_reg          <= 1'b0;
        end
        else
        begin
            addr_reg         <= addr_next;
            auto_inc_reg     <= auto_inc_next;
            io_sel_reg       <= io_sel_next;
            kbd_mode_reg     <= kbd_mode_next;
            clock_div_reg    <= clock_div_next;
            inhibit_low_reg  <= inhibit_low_next;
            inhibit_high_reg <= inhibit_high_next;
            blank_low_reg    <= blank_low_next;
            blank_high_reg   <= blank_high_next;
            underrun_reg     <= underrun_next;
            overrun_reg      <= overrun_next;
            irq_reg          <= irq_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/kdc_checker.sv =====
// Port-level checks for the keyboard/display controller, bound to the top.
// Depends on kdc_pkg and keyboard_display_controller.
module kdc_checker
    import kdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input kdc_result_t result
);

    // Every accepted request yields its result.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted request produced no result");

    // No result appears without a matching accepted request.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a matching request");

    // An accepted key always raises the interrupt.
    a_key_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.key_accepted) |-> result.irq_out)
        else $error("accepted key without interrupt");

    // A key push returns no read data.
    a_key_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.key_accepted) |-> (result.read_value == 8'd0))
        else $error("accepted key with nonzero read value");

endmodule

bind keyboard_display_controller kdc_checker u_kdc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
